[hw/rtl/priority_ready_queue_top_defines.svh]
// Assertion macros for the priority ready queue.
`ifndef PRIORITY_READY_QUEUE_TOP_DEFINES_SVH
`define PRIORITY_READY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PRQ_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRQ_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRQ_ASSERT(name, clk, rst, prop, msg)
`define PRQ_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[hw/rtl/prq_pkg.sv]
// Shared types and constants of the priority ready queue.
package prq_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam int OPCODE_W = 2;
   localparam int TID_W    = 8;
   localparam int PRIO_W   = 4;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = TID_W + PRIO_W;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_CHECK,
      ST_INS_PLACE,
      ST_POP_DATA,
      ST_QRY_READ,
      ST_QRY_CHECK,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/prq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/priority_ready_queue_top.sv]
// Top level of the priority ready queue: sequencer, ring pointers and result register.
// Full insert, empty pop, empty query and unused opcode go straight to FINISH; pop
// reads the head slot; query checks each entry scanned; insert shifts larger ones up.
// Throughput: one item at a time; FINISH holds while the previous result awaits rsp_tready.
// Reset: synchronous, active high; empties the queue and drops any held result.
// Entry storage is not cleared; only slots below the occupancy are read.
`include "priority_ready_queue_top_defines.svh"

module priority_ready_queue_top
   import prq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], item_tid[9:2], item_prio[13:10], zero[15:14]
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], found[2], out_tid[10:3], out_prio[14:11], zero[15]
   output logic [15:0] rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int OW = $clog2(CAPACITY + 1);
   localparam logic [AW:0]   CAP_WRAP = (AW+1)'(CAPACITY);
   localparam logic [OW-1:0] CAP_OCC  = OW'(CAPACITY);

   state_type state_ff, state_in;

   logic [AW-1:0] head_ff, head_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [AW-1:0] idx_ff, idx_in;

   logic [TID_W-1:0]  tid_ff, tid_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_found_ff, res_found_in;
   logic [TID_W-1:0]    res_tid_ff, res_tid_in;
   logic [PRIO_W-1:0]   res_prio_ff, res_prio_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [TID_W-1:0]    rsp_tid_ff, rsp_tid_in;
   logic [PRIO_W-1:0]   rsp_prio_ff, rsp_prio_in;

   logic [OPCODE_W-1:0] req_opcode;
   logic [TID_W-1:0]    req_tid;
   logic [PRIO_W-1:0]   req_prio;
   logic                req_fire;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_off, wr_off;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [TID_W-1:0]   rd_tid;
   logic [PRIO_W-1:0]  rd_prio;

   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= CAP_WRAP) begin
         sum = sum - CAP_WRAP;
      end
      return sum[AW-1:0];
   endfunction

   assign req_opcode = req_tdata[1:0];
   assign req_tid    = req_tdata[9:2];
   assign req_prio   = req_tdata[13:10];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rd_tid  = rd_data[ENTRY_W-1:PRIO_W];
   assign rd_prio = rd_data[PRIO_W-1:0];

   prq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ring_addr(head_ff, wr_off)),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(ring_addr(head_ff, rd_off)),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      tid_ff        <= tid_in;
      prio_ff       <= prio_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_tid_ff    <= res_tid_in;
      res_prio_ff   <= res_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_tid_ff    <= rsp_tid_in;
      rsp_prio_ff   <= rsp_prio_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      tid_in        = tid_ff;
      prio_in       = prio_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_tid_in    = res_tid_ff;
      res_prio_in   = res_prio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_tid_in    = rsp_tid_ff;
      rsp_prio_in   = rsp_prio_ff;
      rd_en         = 1'b0;
      rd_off        = '0;
      wr_en         = 1'b0;
      wr_off        = idx_ff;
      wr_data       = {tid_ff, prio_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               tid_in        = req_tid;
               prio_in       = req_prio;
               res_status_in = STATUS_OK;
               res_found_in  = 1'b0;
               res_tid_in    = '0;
               res_prio_in   = '0;
               idx_in        = '0;
               state_in      = ST_FINISH;
               case (req_opcode)
                  OP_INSERT: begin
                     if (occ_ff == CAP_OCC) begin
                        res_status_in = STATUS_FULL;
                     end else if (occ_ff == '0) begin
                        state_in = ST_INS_PLACE;
                     end else begin
                        idx_in   = occ_ff[AW-1:0];
                        state_in = ST_INS_READ;
                     end
                  end
                  OP_POP: begin
                     if (occ_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_POP_DATA;
                     end
                  end
                  OP_QUERY: begin
                     if (occ_ff != '0) begin
                        state_in = ST_QRY_READ;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_INS_READ: begin
            rd_en    = 1'b1;
            rd_off   = idx_ff - AW'(1);
            state_in = ST_INS_CHECK;
         end
         ST_INS_CHECK: begin
            wr_en = 1'b1;
            if (rd_prio > prio_ff) begin
               wr_data = rd_data;
               idx_in  = idx_ff - AW'(1);
               if (idx_ff == AW'(1)) begin
                  state_in = ST_INS_PLACE;
               end else begin
                  state_in = ST_INS_READ;
               end
            end else begin
               occ_in   = occ_ff + OW'(1);
               state_in = ST_FINISH;
            end
         end
         ST_INS_PLACE: begin
            wr_en    = 1'b1;
            occ_in   = occ_ff + OW'(1);
            state_in = ST_FINISH;
         end
         ST_POP_DATA: begin
            res_tid_in  = rd_tid;
            res_prio_in = rd_prio;
            head_in     = ring_addr(head_ff, AW'(1));
            occ_in      = occ_ff - OW'(1);
            state_in    = ST_FINISH;
         end
         ST_QRY_READ: begin
            rd_en    = 1'b1;
            rd_off   = idx_ff;
            state_in = ST_QRY_CHECK;
         end
         ST_QRY_CHECK: begin
            if (rd_tid == tid_ff) begin
               res_found_in = 1'b1;
               state_in     = ST_FINISH;
            end else if ((OW'(idx_ff) + OW'(1)) == occ_ff) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_QRY_READ;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_tid_in    = res_tid_ff;
               rsp_prio_in   = res_prio_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_prio_ff, rsp_tid_ff, rsp_found_ff, rsp_status_ff};

   `PRQ_ASSERT(a_occ_bound, clock, reset, occ_ff <= CAP_OCC, "occupancy above capacity")
   `PRQ_ASSERT(a_full_reject, clock, reset,
      (req_fire && req_opcode == OP_INSERT && occ_ff == CAP_OCC)
         |=> (res_status_ff == STATUS_FULL && $stable(occ_ff)),
      "insert into full queue not rejected")
   `PRQ_ASSERT(a_empty_pop, clock, reset,
      (req_fire && req_opcode == OP_POP && occ_ff == '0)
         |=> (res_status_ff == STATUS_EMPTY && state_ff == ST_FINISH),
      "pop of empty queue not reported")
   `PRQ_ASSERT(a_occ_change, clock, reset,
      !$stable(occ_ff) |-> ($past(state_ff) == ST_INS_CHECK
         || $past(state_ff) == ST_INS_PLACE || $past(state_ff) == ST_POP_DATA),
      "occupancy changed outside insert or pop")
   `PRQ_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> (state_ff == ST_IDLE && occ_ff == '0 && !rsp_valid_ff),
      "reset did not empty the queue")

endmodule

[verif/priority_ready_queue_top_tb.sv]
// Self-checking testbench for the priority ready queue: directed and random operation streams.
`timescale 1ns / 1ps

module priority_ready_queue_top_tb
   import prq_pkg::*;
();

   localparam int QUEUE_DEPTH = DEFAULT_CAPACITY;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1750;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic                pad;
      logic [PRIO_W-1:0]   out_prio;
      logic [TID_W-1:0]    out_tid;
      logic                found;
      logic [STATUS_W-1:0] status;
   } rsp_fields_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // opcode[1:0], item_tid[9:2], item_prio[13:10], zero[15:14]
   logic [15:0] req_tdata = 16'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // status[1:0], found[2], out_tid[10:3], out_prio[14:11], zero[15]
   logic [15:0] rsp_tdata;

   logic [15:0] pending_requests[$];
   rsp_fields_type awaited_results[$];

   logic [TID_W-1:0]  held_tid[QUEUE_DEPTH];
   logic [PRIO_W-1:0] held_prio[QUEUE_DEPTH];
   int held_count = 0;

   int accepted_count = 0;
   int item_total = 0;
   int error_count = 0;
   int idle_cycles = 0;

   priority_ready_queue_top #(.CAPACITY(QUEUE_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] pack_request(input logic [OPCODE_W-1:0] op,
                                                input logic [TID_W-1:0] tid,
                                                input logic [PRIO_W-1:0] prio);
      return {2'b00, prio, tid, op};
   endfunction

   function automatic int sender_idle_pct(input int done);
      if (done < item_total / 3)
         return 15;
      else if (done < 2 * item_total / 3)
         return 51;
      return 0;
   endfunction

   function automatic int receiver_stall_pct(input int done);
      if (done < item_total / 3)
         return 51;
      else if (done < 2 * item_total / 3)
         return 15;
      return 0;
   endfunction

   // Update the shadow ready queue and queue the result it implies.
   function automatic void apply_queue_op(input logic [15:0] word);
      logic [OPCODE_W-1:0] op;
      logic [TID_W-1:0]    tid;
      logic [PRIO_W-1:0]   prio;
      rsp_fields_type      res;
      int                  pos;
      int                  i;
      op   = word[1:0];
      tid  = word[9:2];
      prio = word[13:10];
      res  = '0;
      case (op)
         OP_INSERT: begin
            if (held_count >= QUEUE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               pos = held_count;
               for (i = 0; i < held_count; i++)
                  if (held_prio[i] > prio && pos == held_count)
                     pos = i;
               for (i = held_count; i > pos; i--) begin
                  held_tid[i]  = held_tid[i-1];
                  held_prio[i] = held_prio[i-1];
               end
               held_tid[pos]  = tid;
               held_prio[pos] = prio;
               held_count++;
            end
         end
         OP_POP: begin
            if (held_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.out_tid  = held_tid[0];
               res.out_prio = held_prio[0];
               for (i = 1; i < held_count; i++) begin
                  held_tid[i-1]  = held_tid[i];
                  held_prio[i-1] = held_prio[i];
               end
               held_count--;
            end
         end
         OP_QUERY: begin
            for (i = 0; i < held_count; i++)
               if (held_tid[i] == tid)
                  res.found = 1'b1;
         end
         default: begin
         end
      endcase
      res.status = (op == OP_QUERY) ? STATUS_OK : res.status;
      awaited_results.push_back(res);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'd0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            apply_queue_op(req_tdata);
            accepted_count <= accepted_count + 1;
         end
         if (pending_requests.size() > 0 &&
             $urandom_range(0, 99) >= sender_idle_pct(accepted_count)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_requests.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct(accepted_count));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (awaited_results.size() == 0) begin
               $display("%0t: result expected none actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  error_count++;
               end
               if (got.found !== want.found) begin
                  $display("%0t: found expected %0d actual %0d",
                           $time, want.found, got.found);
                  error_count++;
               end
               if (got.out_tid !== want.out_tid) begin
                  $display("%0t: out_tid expected %0d actual %0d",
                           $time, want.out_tid, got.out_tid);
                  error_count++;
               end
               if (got.out_prio !== want.out_prio) begin
                  $display("%0t: out_prio expected %0d actual %0d",
                           $time, want.out_prio, got.out_prio);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int generated;
      int burst;
      int mode;
      int pick;
      logic [OPCODE_W-1:0] op;
      logic [TID_W-1:0]    tid;
      logic [PRIO_W-1:0]   prio;

      // Empty queue, unused opcode, field extremes, equal priorities, duplicate ids.
      pending_requests.push_back(pack_request(OP_POP, 8'd0, 4'd0));
      pending_requests.push_back(pack_request(OP_QUERY, 8'd0, 4'd0));
      pending_requests.push_back(pack_request(OP_UNUSED, 8'hFF, 4'hF));
      pending_requests.push_back(pack_request(OP_INSERT, 8'hFF, 4'hF));
      pending_requests.push_back(pack_request(OP_INSERT, 8'h00, 4'h0));
      pending_requests.push_back(pack_request(OP_INSERT, 8'hA5, 4'h7));
      pending_requests.push_back(pack_request(OP_INSERT, 8'h5A, 4'h7));
      pending_requests.push_back(pack_request(OP_INSERT, 8'hFF, 4'h7));
      pending_requests.push_back(pack_request(OP_QUERY, 8'hFF, 4'h0));
      pending_requests.push_back(pack_request(OP_QUERY, 8'h5A, 4'hF));
      pending_requests.push_back(pack_request(OP_QUERY, 8'h33, 4'h0));
      pending_requests.push_back(pack_request(OP_UNUSED, 8'h00, 4'h0));
      pending_requests.push_back(pack_request(OP_INSERT, 8'h80, 4'h8));
      repeat (7)
         pending_requests.push_back(pack_request(OP_POP, 8'h00, 4'h0));

      // Bursts biased to fill, drain or mix, so full and empty are both reached often.
      generated = 0;
      while (generated < RANDOM_ITEMS) begin
         mode  = $urandom_range(0, 2);
         burst = $urandom_range(8, 40);
         repeat (burst) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               op = OP_UNUSED;
            else if (mode == 0)
               op = (pick < 78) ? OP_INSERT : (pick < 88) ? OP_POP : OP_QUERY;
            else if (mode == 1)
               op = (pick < 18) ? OP_INSERT : (pick < 88) ? OP_POP : OP_QUERY;
            else
               op = (pick < 43) ? OP_INSERT : (pick < 78) ? OP_POP : OP_QUERY;
            tid  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                               : 8'($urandom_range(0, 255));
            prio = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                               : 4'($urandom_range(0, 15));
            pending_requests.push_back(pack_request(op, tid, prio));
            generated++;
         end
      end
      item_total = pending_requests.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < item_total || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
